@@ rtl/core/vrank_pkg.sv @@
`timescale 1ns / 1ps

package vrank_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int RANK_W  = 6;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RANK,
        ST_EMIT
    } state_t;

    // control shared by every cell in the chain
    typedef struct packed {
        logic start;   // copy own value into the probe slot, clear rank
        logic rotate;  // compare probe, pass probe to next cell
        logic shift;   // pass rank toward cell 0
    } cell_ctrl_t;

endpackage

@@ rtl/core/vrank_cell.sv @@
`timescale 1ns / 1ps

module vrank_cell
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  vrank_pkg::cell_ctrl_t                 ctrl,
    input  logic                                  load_en,
    input  logic signed [vrank_pkg::VALUE_W-1:0]  load_value,
    input  logic                                  in_list,
    input  logic signed [vrank_pkg::VALUE_W-1:0]  probe_value_in,
    input  logic                                  probe_valid_in,
    input  logic        [vrank_pkg::RANK_W-1:0]   rank_in,
    output logic signed [vrank_pkg::VALUE_W-1:0]  probe_value,
    output logic                                  probe_valid,
    output logic        [vrank_pkg::RANK_W-1:0]   rank_out
);

    logic signed [vrank_pkg::VALUE_W-1:0] value_reg;
    logic signed [vrank_pkg::VALUE_W-1:0] probe_value_reg;
    logic                                 probe_valid_reg;
    logic        [vrank_pkg::RANK_W-1:0]  rank_reg;
    logic                                 smaller;

    assign smaller = probe_valid_reg && (probe_value_reg < value_reg);

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            value_reg <= load_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_valid_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            probe_valid_reg <= in_list;
        end
        else if (ctrl.rotate)
        begin
            probe_valid_reg <= probe_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (ctrl.start)
        begin
            probe_value_reg <= value_reg;
            rank_reg        <= '0;
        end
        else if (ctrl.rotate)
        begin
            probe_value_reg <= probe_value_in;
            if (smaller)
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
        else if (ctrl.shift)
        begin
            rank_reg <= rank_in;
        end
        else
        begin
            // idle: hold probe and rank
            probe_value_reg <= probe_value_reg;
            rank_reg        <= rank_reg;
        end
    end

    assign probe_value = probe_value_reg;
    assign probe_valid = probe_valid_reg;
    assign rank_out    = rank_reg;

endmodule

@@ rtl/core/value_rank_with_sorted_check_core.sv @@
`timescale 1ns / 1ps
// Load: one item transfer per cycle; a non-final item produces no result.
// After the final item transfer the chain ranks in one probe rotation around
// the whole ring, then emits one result per stored value, one per cycle
// unless result_stall holds it back. Reset (rst_n, async, active low) clears the
// control state; stored values stay undefined and need no clearing pass.
module value_rank_with_sorted_check_core
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item channel
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic signed [vrank_pkg::VALUE_W-1:0]  value,
    input  logic                                  final_item,
    // result channel
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic        [vrank_pkg::POS_W-1:0]    position,
    output logic        [vrank_pkg::RANK_W-1:0]   rank,
    output logic                                  end_of_run,
    output logic                                  already_sorted,
    output logic                                  overflowed
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    vrank_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg,  count_next;   // values stored this run
    logic             drop_reg,   drop_next;    // an item was dropped
    logic [CNT_W-1:0] rot_reg,    rot_next;     // ranking cycle counter
    logic [IDX_W-1:0] emit_reg,   emit_next;    // position being emitted
    logic             sorted_reg, sorted_next;  // all ranks so far match

    logic item_xfer;
    logic result_xfer;
    logic store_full;
    logic last_result;
    logic rank_match;

    vrank_pkg::cell_ctrl_t ctrl;

    // chain wiring: probes travel up the ring, ranks travel down to cell 0
    logic signed [vrank_pkg::VALUE_W-1:0] probe_value [MAX_ITEMS];
    logic                                 probe_valid [MAX_ITEMS];
    logic        [vrank_pkg::RANK_W-1:0]  cell_rank   [MAX_ITEMS];

    assign item_xfer   = item_valid && !item_stall;
    assign result_xfer = result_valid && !result_stall;
    assign store_full  = (count_reg == CNT_W'(MAX_ITEMS));
    assign last_result = (CNT_W'(emit_reg) + 1'b1 == count_reg);
    assign rank_match  = (cell_rank[0] == vrank_pkg::RANK_W'(emit_reg));

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vrank_pkg::ST_LOAD:
            begin
                if (item_xfer && final_item)
                begin
                    state_next = vrank_pkg::ST_RANK;
                end
            end
            vrank_pkg::ST_RANK:
            begin
                if (rot_reg == CNT_W'(MAX_ITEMS))
                begin
                    state_next = vrank_pkg::ST_EMIT;
                end
            end
            vrank_pkg::ST_EMIT:
            begin
                if (result_xfer && last_result)
                begin
                    state_next = vrank_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = vrank_pkg::ST_LOAD;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs, chain control and counters
    // ---------------------------------------------------------------
    always_comb
    begin
        item_stall   = 1'b1;
        result_valid = 1'b0;
        ctrl         = '0;
        count_next   = count_reg;
        drop_next    = drop_reg;
        rot_next     = rot_reg;
        emit_next    = emit_reg;
        sorted_next  = sorted_reg;
        unique case (state_reg)
            vrank_pkg::ST_LOAD:
            begin
                item_stall = 1'b0;
                rot_next   = '0;
                if (item_xfer)
                begin
                    if (store_full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            vrank_pkg::ST_RANK:
            begin
                // first cycle seeds the probes, then MAX_ITEMS compare steps
                ctrl.start  = (rot_reg == '0);
                ctrl.rotate = (rot_reg != '0);
                rot_next    = rot_reg + 1'b1;
                emit_next   = '0;
                sorted_next = 1'b1;
            end
            vrank_pkg::ST_EMIT:
            begin
                result_valid = 1'b1;
                if (result_xfer)
                begin
                    ctrl.shift  = 1'b1;
                    emit_next   = emit_reg + 1'b1;
                    sorted_next = sorted_reg && rank_match;
                    if (last_result)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= vrank_pkg::ST_LOAD;
            count_reg  <= '0;
            drop_reg   <= 1'b0;
            rot_reg    <= '0;
            emit_reg   <= '0;
            sorted_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            drop_reg   <= drop_next;
            rot_reg    <= rot_next;
            emit_reg   <= emit_next;
            sorted_reg <= sorted_next;
        end
    end

    // ---------------------------------------------------------------
    // Cell chain: cell k holds load position k
    // ---------------------------------------------------------------
    for (genvar k = 0; k < MAX_ITEMS; k++)
    begin : g_cell
        logic load_en;
        logic in_list;

        assign load_en = item_xfer && !store_full && (count_reg == CNT_W'(k));
        assign in_list = (CNT_W'(k) < count_reg);

        vrank_cell u_cell
        (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .load_en        (load_en),
            .load_value     (value),
            .in_list        (in_list),
            .probe_value_in (probe_value[(k + MAX_ITEMS - 1) % MAX_ITEMS]),
            .probe_valid_in (probe_valid[(k + MAX_ITEMS - 1) % MAX_ITEMS]),
            .rank_in        ((k == MAX_ITEMS - 1) ? '0 : cell_rank[(k + 1) % MAX_ITEMS]),
            .probe_value    (probe_value[k]),
            .probe_valid    (probe_valid[k]),
            .rank_out       (cell_rank[k])
        );
    end

    // result fields come straight from registers and hold while stalled
    assign position       = vrank_pkg::POS_W'(emit_reg);
    assign rank           = cell_rank[0];
    assign end_of_run     = last_result;
    assign already_sorted = last_result && sorted_reg && rank_match;
    assign overflowed     = last_result && drop_reg;

endmodule

@@ rtl/core/vrank_check.sv @@
`timescale 1ns / 1ps

module vrank_check
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  item_valid,
    input logic                                  item_stall,
    input logic                                  final_item,
    input logic                                  result_valid,
    input logic                                  result_stall,
    input logic        [vrank_pkg::POS_W-1:0]    position,
    input logic                                  end_of_run,
    input logic                                  already_sorted,
    input logic                                  overflowed
);

    // no item is taken while results are pending
    a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("item accepted during result run");

    // the final item closes the list
    a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && final_item) |=> item_stall)
        else $error("input not stalled after final item");

    // positions step by one within a run
    a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !end_of_run) |=>
            (result_valid && position == vrank_pkg::POS_W'($past(position) + 1'b1)))
        else $error("result positions not consecutive");

    // run flags appear only on the last result
    a_flags_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !end_of_run) |-> (!already_sorted && !overflowed))
        else $error("run flags set before end of run");

    // the run ends cleanly
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && end_of_run) |=> !result_valid)
        else $error("result valid after end of run");

endmodule

bind value_rank_with_sorted_check_core vrank_check u_vrank_check (.*);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

// Rank-core checker. Lists of signed values are loaded one transfer at a time.
// A reference ranking in this file predicts one result per stored value when
// the final item of a list is taken. The result stream is compared in order
// against the queue of predicted results.
module testbench;

    localparam int MAX_ITEMS   = 64;
    localparam int QUIET_LIMIT = 4000;  // cycles with no transfer on either side
    localparam int HOLD_AT     = 190;   // item count at which the long stall starts
    localparam int HOLD_LEN    = 400;   // length of the long result-side stall
    localparam int RAND_ITEMS  = 300;
    localparam int N_DIRECTED  = 22;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [vrank_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [vrank_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // ways a random list gets its contents
    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,     // few distinct values, so equal values are common
        FILL_RISING,
        FILL_FALLING,
        FILL_EXTREMES
    } fill_mode_t;

    // one result as it appears on the output ports
    typedef struct packed {
        logic [vrank_pkg::POS_W-1:0]  pos;
        logic [vrank_pkg::RANK_W-1:0] rnk;
        logic                         eor;
        logic                         srt;
        logic                         ovf;
    } rank_result_t;

    // One row of the directed table. With typed set, the row is a one-item list
    // and its single result is written out here: position 0, end of run.
    typedef struct packed {
        logic signed [vrank_pkg::VALUE_W-1:0] v;
        logic                                 f;
        logic                                 typed;
        logic [vrank_pkg::RANK_W-1:0]         rnk;
        logic                                 srt;
        logic                                 ovf;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                 item_valid = 1'b0;
    logic                                 item_stall;
    logic signed [vrank_pkg::VALUE_W-1:0] value      = '0;
    logic                                 final_item = 1'b0;

    logic                                 result_valid;
    logic                                 result_stall = 1'b0;
    logic [vrank_pkg::POS_W-1:0]          position;
    logic [vrank_pkg::RANK_W-1:0]         rank;
    logic                                 end_of_run;
    logic                                 already_sorted;
    logic                                 overflowed;

    // local copy of the list held by the block
    logic signed [vrank_pkg::VALUE_W-1:0] list_vals [MAX_ITEMS];
    int unsigned                          list_len     = 0;
    logic                                 list_dropped = 1'b0;

    rank_result_t expected_results [$];

    int send_idle_pct   = 23;
    int recv_idle_pct   = 50;
    int items_accepted  = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;

    // Directed lists: single-item lists at the value extremes, zero and -1 (results typed),
    // short rising/falling lists, equal values, and a shuffled permutation.
    stim_row_t dir_rows [N_DIRECTED] = '{
        '{VAL_MIN, 1'b1, 1'b1, 6'd0, 1'b1, 1'b0},
        '{VAL_MAX, 1'b1, 1'b1, 6'd0, 1'b1, 1'b0},
        '{32'sd0,  1'b1, 1'b1, 6'd0, 1'b1, 1'b0},
        '{-32'sd1, 1'b1, 1'b1, 6'd0, 1'b1, 1'b0},
        '{-32'sd5, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd0,  1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd7,  1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
        '{VAL_MAX, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd0,  1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{VAL_MIN, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd4,  1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd4,  1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd9,  1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
        '{VAL_MIN, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{VAL_MAX, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd3,  1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd1,  1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd2,  1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{32'sd0,  1'b1, 1'b0, 6'd0, 1'b0, 1'b0},
        '{-32'sd1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{-32'sd1, 1'b0, 1'b0, 6'd0, 1'b0, 1'b0},
        '{-32'sd1, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0}
    };

    value_rank_with_sorted_check_core #(
        .MAX_ITEMS      (MAX_ITEMS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .value          (value),
        .final_item     (final_item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .position       (position),
        .rank           (rank),
        .end_of_run     (end_of_run),
        .already_sorted (already_sorted),
        .overflowed     (overflowed)
    );

    always #5 clk = ~clk;

    // Store one accepted item; on a final item, rank the whole list.
    // Rank = number of stored values strictly below; ties share a rank.
    function automatic void rank_item(input logic signed [vrank_pkg::VALUE_W-1:0] v,
                                      input logic f,
                                      ref rank_result_t res [$]);
        int unsigned  n;
        int unsigned  cnt;
        logic         in_order;
        rank_result_t one;
        if (list_len < MAX_ITEMS)
        begin
            list_vals[list_len] = v;
            list_len++;
        end
        else
        begin
            // store full: item lost, flagged on the last result of the run
            list_dropped = 1'b1;
        end
        if (!f)
            return;
        n        = list_len;
        in_order = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            cnt = 0;
            for (int j = 0; j < n; j++)
                if (list_vals[j] < list_vals[i])
                    cnt++;
            if (cnt != i)
                in_order = 1'b0;
            one     = '0;
            one.pos = vrank_pkg::POS_W'(i);
            one.rnk = vrank_pkg::RANK_W'(cnt);
            res.push_back(one);
        end
        // the status flags ride on the last result only
        res[res.size() - 1].eor = 1'b1;
        res[res.size() - 1].srt = in_order;
        res[res.size() - 1].ovf = list_dropped;
        list_len     = 0;
        list_dropped = 1'b0;
    endfunction

    // Offer one item, wait for the transfer, then record what it must produce.
    task automatic send_item(input logic signed [vrank_pkg::VALUE_W-1:0] v, input logic f,
                             input logic typed, input rank_result_t typed_res);
        rank_result_t produced [$];
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        final_item <= f;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        rank_item(v, f, produced);
        if (typed)
            expected_results.push_back(typed_res);
        else
            foreach (produced[k])
                expected_results.push_back(produced[k]);
        items_accepted++;
    endtask

    // Result side stall. Once, after HOLD_AT items, it holds off for a long stall
    // so results back up and the block pushes back on the item side.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (!hold_done && items_accepted >= HOLD_AT)
        begin
            result_stall <= 1'b1;
            hold_left    <= HOLD_LEN;
            hold_done    <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker: every transfer must match the oldest prediction.
    always @(posedge clk)
    begin
        rank_result_t got;
        rank_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{pos: position, rnk: rank, eor: end_of_run,
                    srt: already_sorted, ovf: overflowed};
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result pos=%0d rank=%0d end=%b sorted=%b ovf=%b",
                             $realtime, got.pos, got.rnk, got.eor, got.srt, got.ovf);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.pos !== want.pos || got.rnk !== want.rnk || got.eor !== want.eor
                    || got.srt !== want.srt || got.ovf !== want.ovf)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("%0t: exp pos=%0d rank=%0d end=%b sorted=%b ovf=%b,",
                               $realtime, want.pos, want.rnk, want.eor, want.srt,
                               want.ovf);
                        $display(" got pos=%0d rank=%0d end=%b sorted=%b ovf=%b",
                                 got.pos, got.rnk, got.eor, got.srt, got.ovf);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transfer means the block is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transfer", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        stim_row_t                            row;
        rank_result_t                         typed_res;
        logic signed [vrank_pkg::VALUE_W-1:0] v;
        fill_mode_t                           mode;
        int                                   run_len;
        int                                   run_idx;
        int                                   rand_items;
        int                                   base;
        int                                   step;
        int                                   pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            row       = dir_rows[i];
            typed_res = '{pos: '0, rnk: row.rnk, eor: 1'b1, srt: row.srt, ovf: row.ovf};
            send_item(row.v, row.f, row.typed, typed_res);
        end

        // Random lists. The first two fill the store past capacity and then exactly
        // (the final item itself is dropped in the first); later ones are mostly short.
        run_idx    = 0;
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            if (rand_items >= 210)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (rand_items >= 110)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 23;
            end

            if (run_idx == 0)
                run_len = MAX_ITEMS + 2;
            else if (run_idx == 1)
                run_len = MAX_ITEMS;
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    run_len = $urandom_range(6, 1);
                else if (pick < 90)
                    run_len = $urandom_range(24, 7);
                else
                    run_len = $urandom_range(MAX_ITEMS + 6, MAX_ITEMS - 4);
            end

            mode = fill_mode_t'($urandom_range(FILL_EXTREMES, FILL_RANDOM));
            base = int'($urandom) >>> 2;
            step = $urandom_range(1000, 1);

            for (int k = 0; k < run_len; k++)
            begin
                case (mode)
                    FILL_NARROW:  v = $urandom_range(8) - 4;
                    FILL_RISING:  v = base + k * step;
                    FILL_FALLING: v = base - k * step;
                    FILL_EXTREMES:
                    begin
                        case ($urandom_range(4))
                            0:       v = VAL_MIN;
                            1:       v = VAL_MAX;
                            2:       v = '0;
                            3:       v = -1;
                            default: v = $urandom;
                        endcase
                    end
                    default:      v = $urandom;
                endcase
                send_item(v, k == run_len - 1, 1'b0, '0);
            end
            rand_items += run_len;
            run_idx++;
        end
        item_valid <= 1'b0;

        // drain, then watch for stray results over one full ranking pass
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3 * MAX_ITEMS + 20) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
